>>> src/sorted_table_bound_search_top_defines.svh
// Assertion macros shared by the bound search RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef SORTED_TABLE_BOUND_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BOUND_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stbs_pkg.sv
// Package for the sorted table bound search: field widths, defaults, command
// codes, sequencer states and the structs passed between modules. No dependencies.
package stbs_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_LOWER = 2'd1,
    CMD_UPPER = 2'd2
  } stbs_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } stbs_state_t;

  typedef struct packed {
    logic go;
    logic upper;
  } stbs_query_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic met;
  } stbs_status_t;

endpackage

>>> src/sorted_table_bound_search_top.sv
// Sorted table bound search, top level: command decode, table write path,
// search limit register and result ports. Uses stbs_pkg, stbs_ram and stbs_ctrl.
//
// A write item (command 0) stores one value and leaves busy low; command 3 is
// taken and dropped. A query item (lower or upper bound) raises busy while a
// binary search over indices 0 to last_index runs: each halving step is one
// table read through the RAM's registered port and one compare in the shared
// comparator. Its result appears on the out_ ports for exactly one cycle with
// out_valid high, in the first cycle with busy low again, and the next item can
// be accepted in that same cycle. Results cannot be held off, so the receiver
// must take each one in the cycle it is shown.
module sorted_table_bound_search_top
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  logic [FIELD_W-1:0] in_entry_value,
  input  logic [FIELD_W-1:0] in_search_key,
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_wr_data,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_found_index,
  output logic [FIELD_W-1:0] out_found_value,
  output logic               out_condition_met
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  logic [INDEX_W-1:0]     last_index_r;
  logic                   accept;
  logic                   wr_en;
  stbs_query_t            query;
  stbs_status_t           status;
  logic [AW-1:0]          hi_init;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [AW-1:0]          res_index;
  logic [VALUE_WIDTH-1:0] res_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_index_r <= '0;
    end else if (cfg_wr_en) begin
      last_index_r <= cfg_wr_data;
    end
  end

  assign busy   = status.busy;
  assign accept = start && !status.busy;

  always_comb begin
    wr_en       = 1'b0;
    query.go    = 1'b0;
    query.upper = 1'b0;
    case (in_command)
      CMD_WRITE: begin
        wr_en = accept && (CW'(in_entry_index) < CW'(TABLE_DEPTH));
      end
      CMD_LOWER: begin
        query.go = accept;
      end
      CMD_UPPER: begin
        query.go    = accept;
        query.upper = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign hi_init = (CW'(last_index_r) >= CW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1)
                                                           : AW'(last_index_r);

  stbs_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(in_entry_index)),
    .wdata(VALUE_WIDTH'(in_entry_value)),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  stbs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .query    (query),
    .key      (VALUE_WIDTH'(in_search_key)),
    .hi_init  (hi_init),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .status   (status),
    .res_index(res_index),
    .res_value(res_value)
  );

  assign out_valid         = status.done;
  assign out_found_index   = INDEX_W'(res_index);
  assign out_found_value   = FIELD_W'(res_value);
  assign out_condition_met = status.met;

endmodule

>>> src/stbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/stbs_ctrl.sv
// Search sequencer: holds the lo/hi window and drives one shared comparator
// against the table read port to halve it step by step. Uses stbs_pkg.
`include "sorted_table_bound_search_top_defines.svh"

module stbs_ctrl
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stbs_query_t            query,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [AW-1:0]          hi_init,
  output logic [AW-1:0]          rd_addr,
  input  logic [VALUE_WIDTH-1:0] rd_data,
  output stbs_status_t           status,
  output logic [AW-1:0]          res_index,
  output logic [VALUE_WIDTH-1:0] res_value
);

  stbs_state_t            state_r, state_nxt;
  logic [AW-1:0]          lo_r, lo_nxt;
  logic [AW-1:0]          hi_r, hi_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                   upper_r, upper_nxt;
  logic                   done_r, done_nxt;
  logic                   met_r, met_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;

  logic [AW:0]   sum;
  logic [AW-1:0] mid;
  logic          meets;

  assign sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid   = sum[AW:1];
  assign meets = upper_r ? (rd_data > key_r) : (rd_data >= key_r);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    key_nxt   = key_r;
    upper_nxt = upper_r;
    done_nxt  = 1'b0;
    met_nxt   = met_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    rd_addr   = lo_r;
    case (state_r)
      S_IDLE: begin
        if (query.go) begin
          lo_nxt    = '0;
          hi_nxt    = hi_init;
          key_nxt   = key;
          upper_nxt = query.upper;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid;
          state_nxt = S_CMP;
        end else begin
          rd_addr   = lo_r;
          state_nxt = S_FIN;
        end
      end
      S_CMP: begin
        if (meets) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + AW'(1);
        end
        state_nxt = S_ADDR;
      end
      S_FIN: begin
        done_nxt  = 1'b1;
        met_nxt   = meets;
        idx_nxt   = lo_r;
        val_nxt   = rd_data;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    key_r   <= key_nxt;
    upper_r <= upper_nxt;
    met_r   <= met_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
  end

  assign status.busy = (state_r != S_IDLE);
  assign status.done = done_r;
  assign status.met  = met_r;
  assign res_index   = idx_r;
  assign res_value   = val_r;

  `STBS_ASSERT_IMP(a_window_ordered, clk, rst_n, state_r != S_IDLE, lo_r <= hi_r, "search window inverted")
  `STBS_ASSERT_NXT(a_window_shrinks, clk, rst_n, state_r == S_CMP, (hi_r - lo_r) < ($past(hi_r) - $past(lo_r)), "halving step did not narrow the window")
  `STBS_ASSERT_IMP(a_done_after_fin, clk, rst_n, done_r, $past(state_r) == S_FIN, "result strobe without a final compare")
  `STBS_ASSERT_NXT(a_query_starts, clk, rst_n, state_r == S_IDLE && query.go, state_r == S_ADDR && lo_r == '0, "query not launched")

endmodule

>>> sim/stbs_search_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted table bound search: follows the command, limit and result
// ports, predicts each query's outcome from its own table copy and compares.
// Depends on stbs_pkg only.
module stbs_search_checker
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  logic [FIELD_W-1:0] in_entry_value,
  input  logic [FIELD_W-1:0] in_search_key,
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_wr_data,
  input  logic               out_valid,
  input  logic [INDEX_W-1:0] out_found_index,
  input  logic [FIELD_W-1:0] out_found_value,
  input  logic               out_condition_met,
  output int unsigned        error_count,
  output int unsigned        pending_count,
  output int unsigned        query_count,
  output int unsigned        write_count
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [FIELD_W-1:0] value;
    logic               met;
  } bound_result_t;

  logic [FIELD_W-1:0] table_copy [TABLE_DEPTH];
  logic [INDEX_W-1:0] search_limit = '0;
  bound_result_t      awaited_results [$];
  int unsigned        mismatches = 0;
  int unsigned        queries = 0;
  int unsigned        writes = 0;

  function automatic logic qualifies(input logic [FIELD_W-1:0] stored,
                                     input logic [FIELD_W-1:0] key, input logic upper);
    return upper ? (stored > key) : (stored >= key);
  endfunction

  function automatic bound_result_t bound_search(input logic [FIELD_W-1:0] key,
                                                 input logic upper);
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    bound_result_t found;
    lo = 0;
    hi = (search_limit >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : search_limit;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (qualifies(table_copy[mid], key, upper)) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    found.index = lo[INDEX_W-1:0];
    found.value = table_copy[lo];
    found.met   = qualifies(table_copy[lo], key, upper);
    return found;
  endfunction

  always @(posedge clk) begin : monitor
    bound_result_t got;
    bound_result_t want;
    if (!rst_n) begin
      search_limit = '0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        got = {out_found_index, out_found_value, out_condition_met};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected result index %0d value %h met %0b", $time,
                     got.index, got.value, got.met);
          end
        end else begin
          want = awaited_results.pop_front();
          queries++;
          if (got.index !== want.index || got.value !== want.value || got.met !== want.met) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: expected index %0d value %h met %0b, got index %0d value %h met %0b",
                       $time, want.index, want.value, want.met, got.index, got.value, got.met);
            end
          end
        end
      end
      if (start && !busy) begin
        case (in_command)
          CMD_WRITE: begin
            if (in_entry_index < TABLE_DEPTH) begin
              table_copy[in_entry_index] = in_entry_value;
            end
            writes++;
          end
          CMD_LOWER: awaited_results.push_back(bound_search(in_search_key, 1'b0));
          CMD_UPPER: awaited_results.push_back(bound_search(in_search_key, 1'b1));
          default: begin
          end
        endcase
      end
      if (cfg_wr_en) begin
        search_limit = cfg_wr_data;
      end
    end
    error_count   <= mismatches;
    pending_count <= awaited_results.size();
    query_count   <= queries;
    write_count   <= writes;
  end

endmodule

>>> sim/sorted_table_bound_search_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sorted table bound search: clock, reset, table loads,
// queries, limit writes, watchdog and verdict. Depends on stbs_pkg, the RTL top
// and stbs_search_checker.
module sorted_table_bound_search_top_tb;
  import stbs_pkg::*;

  localparam int unsigned        TABLE_DEPTH     = DEF_TABLE_DEPTH;
  localparam int unsigned        QUERY_LATENCY   = 24;
  localparam int unsigned        RANDOM_ITEMS    = 420;
  localparam int unsigned        WATCHDOG_CYCLES = 2000;
  localparam int unsigned        IDLE_PERCENT    = 29;
  localparam logic [CMD_W-1:0]   CMD_UNUSED      = 2'd3;
  localparam logic [INDEX_W-1:0] LIMIT_MAX       = '1;
  localparam logic [INDEX_W-1:0] FINAL_LAST      = 10'd255;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [CMD_W-1:0]   in_command = CMD_WRITE;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic [FIELD_W-1:0] in_entry_value = '0;
  logic [FIELD_W-1:0] in_search_key = '0;
  logic               cfg_wr_en = 1'b0;
  logic [INDEX_W-1:0] cfg_wr_data = '0;
  logic               busy;
  logic               out_valid;
  logic [INDEX_W-1:0] out_found_index;
  logic [FIELD_W-1:0] out_found_value;
  logic               out_condition_met;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned query_count;
  int unsigned write_count;
  int unsigned item_count = 0;
  int unsigned limit_settings = 0;
  int unsigned stall_cycles = 0;
  bit          steady = 1'b0;

  logic [FIELD_W-1:0] table_image [TABLE_DEPTH];

  sorted_table_bound_search_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(DEF_VALUE_WIDTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_search_key    (in_search_key),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_found_index  (out_found_index),
    .out_found_value  (out_found_value),
    .out_condition_met(out_condition_met)
  );

  stbs_search_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) search_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_search_key    (in_search_key),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_found_index  (out_found_index),
    .out_found_value  (out_found_value),
    .out_condition_met(out_condition_met),
    .error_count      (error_count),
    .pending_count    (pending_count),
    .query_count      (query_count),
    .write_count      (write_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_CYCLES);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                       input logic [FIELD_W-1:0] val, input logic [FIELD_W-1:0] key);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PERCENT) idle_cycle();
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_search_key  <= key;
    do @(posedge clk); while (busy);
    if (cmd != CMD_UNUSED) item_count++;
  endtask

  task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    issue(CMD_WRITE, idx, val, $urandom());
    table_image[idx] = val;
  endtask

  task automatic query(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] key);
    issue(cmd, INDEX_W'($urandom()), $urandom(), key);
  endtask

  // Limit writes happen only with the block idle and every result collected.
  task automatic set_limit(input logic [INDEX_W-1:0] last);
    idle_cycle();
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (QUERY_LATENCY) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= last;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_settings++;
  endtask

  task automatic load_sorted(input int unsigned count);
    longint unsigned level;
    int unsigned     step_span;
    int unsigned     i;
    int unsigned     slot;
    bit              downward;
    case ($urandom_range(2))
      0: step_span = 3;
      1: step_span = 5000;
      default: step_span = 32'hFFFF_FFFF / count;
    endcase
    level = ($urandom_range(3) == 0) ? 0 : $urandom_range(step_span);
    for (i = 0; i < count; i++) begin
      table_image[i] = level[FIELD_W-1:0];
      level += $urandom_range(step_span);
    end
    if ($urandom_range(3) == 0) table_image[count-1] = '1;
    downward = ($urandom_range(3) == 0);
    for (i = 0; i < count; i++) begin
      slot = downward ? count - 1 - i : i;
      write_entry(INDEX_W'(slot), table_image[slot]);
    end
  endtask

  // Keys mostly sit on or next to stored values so that bounds land on duplicates.
  function automatic logic [FIELD_W-1:0] pick_key(input logic [INDEX_W-1:0] last);
    logic [FIELD_W-1:0] near;
    near = table_image[$urandom_range(last)];
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom();
      4, 5: return near - 1;
      6, 7: return near + 1;
      default: return near;
    endcase
  endfunction

  task automatic run_phase(input logic [INDEX_W-1:0] last, input int unsigned queries);
    int unsigned n;
    int unsigned r;
    set_limit(last);
    load_sorted(last + 1);
    if ($urandom_range(5) == 0) begin
      write_entry(INDEX_W'($urandom_range(last)), $urandom());
    end
    for (n = 0; n < queries; n++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        issue(CMD_UNUSED, INDEX_W'($urandom()), $urandom(), $urandom());
      end else if (r < 14 && last != LIMIT_MAX) begin
        write_entry(INDEX_W'($urandom_range(LIMIT_MAX, last + 1)), $urandom());
      end else begin
        query(($urandom_range(1) == 1) ? CMD_UPPER : CMD_LOWER, pick_key(last));
      end
    end
  endtask

  initial begin
    int unsigned        r;
    int unsigned        phase;
    int unsigned        base;
    logic [INDEX_W-1:0] span_last;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_limit(7);
    write_entry(0, 32'd0);
    write_entry(1, 32'd5);
    write_entry(2, 32'd5);
    write_entry(3, 32'd5);
    write_entry(4, 32'd100);
    write_entry(5, 32'd1000);
    write_entry(6, 32'h8000_0000);
    write_entry(7, 32'hFFFF_FFFF);
    query(CMD_LOWER, 32'd0);
    query(CMD_UPPER, 32'd0);
    query(CMD_LOWER, 32'd5);
    query(CMD_UPPER, 32'd5);
    query(CMD_LOWER, 32'd6);
    query(CMD_UPPER, 32'hFFFF_FFFE);
    query(CMD_LOWER, 32'hFFFF_FFFF);
    query(CMD_UPPER, 32'hFFFF_FFFF);
    issue(CMD_UNUSED, LIMIT_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    set_limit(0);
    query(CMD_LOWER, 32'd1);
    query(CMD_UPPER, 32'd0);
    query(CMD_LOWER, 32'd0);

    // An out-of-order entry makes the halving steps land on an arbitrary index.
    set_limit(3);
    write_entry(1, 32'hFFFF_FFFF);
    query(CMD_LOWER, 32'd5);
    query(CMD_UPPER, 32'd0);

    base  = item_count;
    phase = 0;
    while (item_count - base < RANDOM_ITEMS) begin
      steady = (phase == 4 || phase == 5);
      r = $urandom_range(9);
      if (r == 0) begin
        span_last = 0;
      end else if (r == 1) begin
        span_last = 1;
      end else if (r == 2) begin
        span_last = INDEX_W'($urandom_range(200, 41));
      end else begin
        span_last = INDEX_W'($urandom_range(40, 2));
      end
      run_phase(span_last, $urandom_range(30, 10));
      phase++;
    end
    steady = 1'b0;
    run_phase(FINAL_LAST, 40);

    idle_cycle();
    while (pending_count != 0) @(posedge clk);
    repeat (QUERY_LATENCY) @(posedge clk);
    $display("Run covered %0d table writes and %0d checked queries under %0d limit settings.",
             write_count, query_count, limit_settings);
    $display("Limits spanned 0 to %0d, with duplicate runs, extreme keys and unsorted tables.",
             FINAL_LAST);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
